### rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, quiet while rst_n is low
`define SLD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, quiet while rst_n is low
`define SLD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sld_pkg.sv
// shared types, constants, year table and helper functions
package sld_pkg;

    localparam int FIRST_YEAR      = 1900;
    localparam int LAST_YEAR       = 2100;
    localparam int ROM_WORDS       = 201;
    localparam int NUM_YEARS_RAW   = LAST_YEAR - FIRST_YEAR + 1;
    localparam int NUM_YEARS       = (NUM_YEARS_RAW > ROM_WORDS) ? ROM_WORDS : NUM_YEARS_RAW;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int DAYS_W   = 17;
    localparam int WORD_W   = 17;
    localparam int IDX_W    = 8;
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int INDEX_W  = 4;
    localparam int LEN_W    = 9;

    localparam logic [DAYS_W-1:0]  MAX_OFFSET      = 17'd73383;
    localparam logic [LEN_W-1:0]   MIN_YEAR_LEN    = 9'd348;
    localparam logic [LEN_W-1:0]   SHORT_MONTH     = 9'd29;
    localparam logic [LEN_W-1:0]   LONG_MONTH      = 9'd30;
    localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
    localparam logic [DAY_W-1:0]   MAX_DAY         = 5'd30;
    localparam int                 LEAP_LONG_BIT   = 16;
    localparam logic [4:0]         MONTH_TOP_BIT   = 5'd16;

    localparam int STEM_COUNT   = 10;
    localparam int BRANCH_COUNT = 12;
    localparam logic [INDEX_W-1:0] STEM_START   = INDEX_W'((FIRST_YEAR - 4) % STEM_COUNT);
    localparam logic [INDEX_W-1:0] BRANCH_START = INDEX_W'((FIRST_YEAR - 4) % BRANCH_COUNT);
    localparam logic [INDEX_W-1:0] STEM_LAST    = INDEX_W'(STEM_COUNT - 1);
    localparam logic [INDEX_W-1:0] BRANCH_LAST  = INDEX_W'(BRANCH_COUNT - 1);

    typedef struct packed {
        logic              in_range;
        logic [DAYS_W-1:0] offset;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_chan_t;

    typedef struct packed {
        logic               valid_res;
        logic [YEAR_W-1:0]  lunar_year;
        logic [MONTH_W-1:0] lunar_month;
        logic [DAY_W-1:0]   lunar_day;
        logic               leap_flag;
        logic [INDEX_W-1:0] stem_index;
        logic [INDEX_W-1:0] branch_index;
    } res_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_YEAR,
        BK_MONTH,
        BK_HOLD
    } back_state_t;

    // bit 16: leap month long, bits 15..4: months 1..12 long, bits 3..0: leap month
    localparam logic [WORD_W-1:0] YEAR_ROM [ROM_WORDS] = '{
        17'h04bd8, 17'h04ae0, 17'h0a570, 17'h054d5, 17'h0d260,
        17'h0d950, 17'h16554, 17'h056a0, 17'h09ad0, 17'h055d2,
        17'h04ae0, 17'h0a5b6, 17'h0a4d0, 17'h0d250, 17'h1d255,
        17'h0b540, 17'h0d6a0, 17'h0ada2, 17'h095b0, 17'h14977,
        17'h04970, 17'h0a4b0, 17'h0b4b5, 17'h06a50, 17'h06d40,
        17'h1ab54, 17'h02b60, 17'h09570, 17'h052f2, 17'h04970,
        17'h06566, 17'h0d4a0, 17'h0ea50, 17'h16a95, 17'h05ad0,
        17'h02b60, 17'h186e3, 17'h092e0, 17'h1c8d7, 17'h0c950,
        17'h0d4a0, 17'h1d8a6, 17'h0b550, 17'h056a0, 17'h1a5b4,
        17'h025d0, 17'h092d0, 17'h0d2b2, 17'h0a950, 17'h0b557,
        17'h06ca0, 17'h0b550, 17'h15355, 17'h04da0, 17'h0a5b0,
        17'h14573, 17'h052b0, 17'h0a9a8, 17'h0e950, 17'h06aa0,
        17'h0aea6, 17'h0ab50, 17'h04b60, 17'h0aae4, 17'h0a570,
        17'h05260, 17'h0f263, 17'h0d950, 17'h05b57, 17'h056a0,
        17'h096d0, 17'h04dd5, 17'h04ad0, 17'h0a4d0, 17'h0d4d4,
        17'h0d250, 17'h0d558, 17'h0b540, 17'h0b6a0, 17'h195a6,
        17'h095b0, 17'h049b0, 17'h0a974, 17'h0a4b0, 17'h0b27a,
        17'h06a50, 17'h06d40, 17'h0af46, 17'h0ab60, 17'h09570,
        17'h04af5, 17'h04970, 17'h064b0, 17'h074a3, 17'h0ea50,
        17'h06b58, 17'h05ac0, 17'h0ab60, 17'h096d5, 17'h092e0,
        17'h0c960, 17'h0d954, 17'h0d4a0, 17'h0da50, 17'h07552,
        17'h056a0, 17'h0abb7, 17'h025d0, 17'h092d0, 17'h0cab5,
        17'h0a950, 17'h0b4a0, 17'h0baa4, 17'h0ad50, 17'h055d9,
        17'h04ba0, 17'h0a5b0, 17'h15176, 17'h052b0, 17'h0a930,
        17'h07954, 17'h06aa0, 17'h0ad50, 17'h05b52, 17'h04b60,
        17'h0a6e6, 17'h0a4e0, 17'h0d260, 17'h0ea65, 17'h0d530,
        17'h05aa0, 17'h076a3, 17'h096d0, 17'h04afb, 17'h04ad0,
        17'h0a4d0, 17'h1d0b6, 17'h0d250, 17'h0d520, 17'h0dd45,
        17'h0b5a0, 17'h056d0, 17'h055b2, 17'h049b0, 17'h0a577,
        17'h0a4b0, 17'h0aa50, 17'h1b255, 17'h06d20, 17'h0ada0,
        17'h14b63, 17'h09370, 17'h049f8, 17'h04970, 17'h064b0,
        17'h168a6, 17'h0ea50, 17'h06aa0, 17'h1a6c4, 17'h0aae0,
        17'h092e0, 17'h0d2e3, 17'h0c960, 17'h0d557, 17'h0d4a0,
        17'h0da50, 17'h05d55, 17'h056a0, 17'h0a6d0, 17'h055d4,
        17'h052d0, 17'h0a9b8, 17'h0a950, 17'h0b4a0, 17'h0b6a6,
        17'h0ad50, 17'h055a0, 17'h0aba4, 17'h0a5b0, 17'h052b0,
        17'h0b273, 17'h06930, 17'h07337, 17'h06aa0, 17'h0ad50,
        17'h14b55, 17'h04b60, 17'h0a570, 17'h054e4, 17'h0d160,
        17'h0e968, 17'h0d520, 17'h0daa0, 17'h16aa6, 17'h056d0,
        17'h04ae0, 17'h0a9d4, 17'h0a2d0, 17'h0d150, 17'h0f252,
        17'h0d520
    };

    function automatic logic [WORD_W-1:0] rom_word(input logic [IDX_W-1:0] idx);
        logic [WORD_W-1:0] w;
        w = '0;
        if (int'(idx) < ROM_WORDS)
        begin
            w = YEAR_ROM[idx];
        end
        return w;
    endfunction

    function automatic logic [LEN_W-1:0] leap_len(input logic [WORD_W-1:0] w);
        logic [LEN_W-1:0] len;
        len = '0;
        if (w[3:0] != 4'd0)
        begin
            len = w[LEAP_LONG_BIT] ? LONG_MONTH : SHORT_MONTH;
        end
        return len;
    endfunction

    function automatic logic [LEN_W-1:0] month_len(input logic [WORD_W-1:0] w,
                                                   input logic [MONTH_W-1:0] m);
        logic [WORD_W-1:0] sh;
        sh = w >> (MONTH_TOP_BIT - {1'b0, m});
        return sh[0] ? LONG_MONTH : SHORT_MONTH;
    endfunction

    function automatic logic [LEN_W-1:0] year_len(input logic [WORD_W-1:0] w);
        logic [LEN_W-1:0] sum;
        sum = MIN_YEAR_LEN;
        for (int b = 4; b <= 15; b++)
        begin
            sum = sum + LEN_W'(w[b]);
        end
        return sum + leap_len(w);
    endfunction

endpackage

### rtl/sld_in_if.sv
// input channel: day count since the base date
interface sld_in_if;
    import sld_pkg::*;

    logic              valid;
    logic              ready;
    logic [DAYS_W-1:0] days_since_base;

    modport source (output valid, output days_since_base, input ready);
    modport sink   (input valid, input days_since_base, output ready);
endinterface

### rtl/sld_out_if.sv
// output channel: converted lunar date
interface sld_out_if;
    import sld_pkg::*;

    logic               valid;
    logic               ready;
    logic               valid_res;
    logic [YEAR_W-1:0]  lunar_year;
    logic [MONTH_W-1:0] lunar_month;
    logic [DAY_W-1:0]   lunar_day;
    logic               leap_flag;
    logic [INDEX_W-1:0] stem_index;
    logic [INDEX_W-1:0] branch_index;

    modport source (output valid, output valid_res, output lunar_year, output lunar_month,
                    output lunar_day, output leap_flag, output stem_index,
                    output branch_index, input ready);
    modport sink   (input valid, input valid_res, input lunar_year, input lunar_month,
                    input lunar_day, input leap_flag, input stem_index,
                    input branch_index, output ready);
endinterface

### rtl/sld_front.sv
// front end: takes transactions, range-checks the offset, pushes into the queue
module sld_front (
    input  logic             clk,
    input  logic             rst_n,
    sld_in_if.sink           item,
    output sld_pkg::q_chan_t push,
    input  logic             push_ready
);
    import sld_pkg::*;

    logic              stage_valid_reg, stage_valid_next;
    logic [DAYS_W-1:0] stage_off_reg;
    logic              stage_in_range_reg;
    logic              take;

    assign item.ready = !stage_valid_reg || push_ready;
    assign take       = item.valid && item.ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (take)
        begin
            stage_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_off_reg      <= item.days_since_base;
            stage_in_range_reg <= (item.days_since_base <= MAX_OFFSET);
        end
    end

    assign push.valid          = stage_valid_reg;
    assign push.entry.in_range = stage_in_range_reg;
    assign push.entry.offset   = stage_off_reg;
endmodule

### rtl/sld_fifo.sv
// short queue between front and back end
module sld_fifo #(
    parameter int DEPTH = sld_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  sld_pkg::q_chan_t push,
    output logic             push_ready,
    output sld_pkg::q_chan_t head,
    input  logic             pop
);
    import sld_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_entry_t         mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.entry;
        end
    end
endmodule

### rtl/sld_back.sv
// back end: year walk, month walk and the output register
module sld_back (
    input  logic             clk,
    input  logic             rst_n,
    input  sld_pkg::q_chan_t head,
    output logic             pop,
    sld_out_if.source        res
);
    import sld_pkg::*;

    back_state_t        state_reg, state_next;
    logic [DAYS_W-1:0]  off_reg, off_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [INDEX_W-1:0] stem_reg, stem_next;
    logic [INDEX_W-1:0] branch_reg, branch_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic               in_leap_reg, in_leap_next;
    res_t               pend_reg, pend_next;
    res_t               out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic [WORD_W-1:0]  word;
    logic [LEN_W-1:0]   ylen;
    logic [LEN_W-1:0]   cur_len;
    logic [DAYS_W-1:0]  off_sub;
    logic               year_end, year_hit, month_hit, take_leap, last_month, out_free;
    res_t               res_found, res_over;

    // walk datapath
    always_comb
    begin
        word       = rom_word(idx_reg);
        ylen       = year_len(word);
        cur_len    = in_leap_reg ? leap_len(word) : month_len(word, month_reg);
        off_sub    = off_reg - DAYS_W'(cur_len);
        year_end   = (idx_reg == IDX_W'(NUM_YEARS));
        year_hit   = (off_reg < DAYS_W'(ylen));
        month_hit  = (off_reg < DAYS_W'(cur_len));
        take_leap  = !in_leap_reg && (month_reg == word[3:0]);
        last_month = (month_reg == MONTHS_PER_YEAR) && !take_leap;
        out_free   = !out_valid_reg || res.ready;

        res_found.valid_res    = 1'b1;
        res_found.lunar_year   = YEAR_W'(FIRST_YEAR) + YEAR_W'(idx_reg);
        res_found.lunar_month  = month_reg;
        res_found.lunar_day    = off_reg[DAY_W-1:0] + 1'b1;
        res_found.leap_flag    = in_leap_reg;
        res_found.stem_index   = stem_reg;
        res_found.branch_index = branch_reg;

        // month walk overrun: saturate the day
        res_over           = res_found;
        res_over.leap_flag = 1'b0;
        res_over.lunar_day = (off_sub >= DAYS_W'(MAX_DAY)) ? MAX_DAY
                                                            : off_sub[DAY_W-1:0] + 1'b1;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = head.entry.in_range ? BK_YEAR : BK_HOLD;
                end
            end
            BK_YEAR:
            begin
                if (year_end)
                begin
                    state_next = BK_HOLD;
                end
                else if (year_hit)
                begin
                    state_next = BK_MONTH;
                end
            end
            BK_MONTH:
            begin
                if (month_hit || last_month)
                begin
                    state_next = BK_HOLD;
                end
            end
            BK_HOLD:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // outputs and datapath updates
    always_comb
    begin
        pop            = 1'b0;
        off_next       = off_reg;
        idx_next       = idx_reg;
        stem_next      = stem_reg;
        branch_next    = branch_reg;
        month_next     = month_reg;
        in_leap_next   = in_leap_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !res.ready;
        case (state_reg)
            BK_IDLE:
            begin
                if (head.valid)
                begin
                    pop         = 1'b1;
                    off_next    = head.entry.offset;
                    idx_next    = '0;
                    stem_next   = STEM_START;
                    branch_next = BRANCH_START;
                    pend_next   = '0;
                end
            end
            BK_YEAR:
            begin
                if (year_end)
                begin
                    pend_next = '0;
                end
                else if (year_hit)
                begin
                    month_next   = MONTH_W'(1);
                    in_leap_next = 1'b0;
                end
                else
                begin
                    off_next    = off_reg - DAYS_W'(ylen);
                    idx_next    = idx_reg + 1'b1;
                    stem_next   = (stem_reg == STEM_LAST) ? '0 : stem_reg + 1'b1;
                    branch_next = (branch_reg == BRANCH_LAST) ? '0 : branch_reg + 1'b1;
                end
            end
            BK_MONTH:
            begin
                if (month_hit)
                begin
                    pend_next = res_found;
                end
                else if (take_leap)
                begin
                    off_next     = off_sub;
                    in_leap_next = 1'b1;
                end
                else if (month_reg == MONTHS_PER_YEAR)
                begin
                    pend_next = res_over;
                end
                else
                begin
                    off_next     = off_sub;
                    month_next   = month_reg + 1'b1;
                    in_leap_next = 1'b0;
                end
            end
            BK_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = pend_reg;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg     <= off_next;
        idx_reg     <= idx_next;
        stem_reg    <= stem_next;
        branch_reg  <= branch_next;
        month_reg   <= month_next;
        in_leap_reg <= in_leap_next;
        pend_reg    <= pend_next;
        out_reg     <= out_next;
    end

    assign res.valid        = out_valid_reg;
    assign res.valid_res    = out_reg.valid_res;
    assign res.lunar_year   = out_reg.lunar_year;
    assign res.lunar_month  = out_reg.lunar_month;
    assign res.lunar_day    = out_reg.lunar_day;
    assign res.leap_flag    = out_reg.leap_flag;
    assign res.stem_index   = out_reg.stem_index;
    assign res.branch_index = out_reg.branch_index;
endmodule

### rtl/solar_to_lunar_date_core.sv
// top level of the solar to lunar date converter
//
// converts a count of whole days since 1900-01-31 (lunar new year 1900) into
// the chinese lunar year, month, day, a leap-month flag and the stem and
// branch indices of the year. one result transaction comes out for every
// input transaction, in order. offsets above 73383 (past 2100-12-31) give
// valid_res low and every other field zero. a conversion passes through the
// front stage and the queue before the back end pops it, then walks the
// table year word by year word and then month by month, a leap month
// included, and finally loads the output register before the result
// transaction is offered; an out-of-range offset skips both walks. the back
// end works on one conversion at a time, passes through its idle state
// between conversions, and its one-year-per-cycle table walk sets the rate.
// the front end keeps taking transactions into a small queue, while it has
// room, when the back end is busy or the output register waits to be taken.
module solar_to_lunar_date_core #(
    parameter int QUEUE_DEPTH = sld_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    sld_in_if.sink    item,
    sld_out_if.source res
);
    import sld_pkg::*;

    // front to queue
    q_chan_t q_push;
    logic    q_push_ready;

    // queue to back end
    q_chan_t q_head;
    logic    q_pop;

    // accept, range check, stage
    sld_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .push       (q_push),
        .push_ready (q_push_ready)
    );

    // decouples intake from the long table walk
    sld_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_ready (q_push_ready),
        .head       (q_head),
        .pop        (q_pop)
    );

    // year walk, month walk, result register
    sld_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (q_head),
        .pop   (q_pop),
        .res   (res)
    );
endmodule

### rtl/sld_checker.sv
// port-level checker for the lunar date converter and its bind
`include "assert_macros.svh"

module sld_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        valid_res,
    input logic [sld_pkg::YEAR_W-1:0]  lunar_year,
    input logic [sld_pkg::MONTH_W-1:0] lunar_month,
    input logic [sld_pkg::DAY_W-1:0]   lunar_day,
    input logic                        leap_flag,
    input logic [sld_pkg::INDEX_W-1:0] stem_index,
    input logic [sld_pkg::INDEX_W-1:0] branch_index
);
    import sld_pkg::*;

    // a stalled result stays valid and holds valid_res, year and day
    `SLD_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(valid_res) && $stable(lunar_year) && $stable(lunar_day),
        "stalled result transaction changed")

    // invalid result carries all-zero fields
    `SLD_ASSERT_IMP(a_invalid_zero, out_valid && !valid_res,
        lunar_year == '0 && lunar_month == '0 && lunar_day == '0 && !leap_flag &&
        stem_index == '0 && branch_index == '0,
        "invalid result has nonzero fields")

    // valid result lies in the calendar range
    `SLD_ASSERT_IMP(a_valid_range, out_valid && valid_res,
        lunar_month >= MONTH_W'(1) && lunar_month <= MONTHS_PER_YEAR &&
        lunar_day >= DAY_W'(1) && lunar_day <= MAX_DAY &&
        lunar_year >= YEAR_W'(FIRST_YEAR) && lunar_year <= YEAR_W'(LAST_YEAR),
        "valid result outside calendar range")

    // cycle indices stay within their cycles
    `SLD_ASSERT_IMP(a_cycle_range, out_valid && valid_res,
        stem_index <= STEM_LAST && branch_index <= BRANCH_LAST,
        "stem or branch index out of range")
endmodule

bind solar_to_lunar_date_core sld_checker u_sld_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (res.valid),
    .out_ready    (res.ready),
    .valid_res    (res.valid_res),
    .lunar_year   (res.lunar_year),
    .lunar_month  (res.lunar_month),
    .lunar_day    (res.lunar_day),
    .leap_flag    (res.leap_flag),
    .stem_index   (res.stem_index),
    .branch_index (res.branch_index)
);
